[design/i2cm_pkg.sv]
// shared types and constants of the i2c master bit engine
// no dependencies; compiled first

package i2cm_pkg;

	// register reset values and default queue depth
	localparam logic [7:0] HALF_PERIOD_RST = 8'd3;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;
	localparam int         QUEUE_DEPTH_DEF = 2;

	// configuration register indexes
	localparam int         REG_IDX_W       = 1;
	localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'b1;

	// command codes on the op field
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// classified command carried in the queue
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	// line phases of the sequencer
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_A,
		PH_ST_B,
		PH_ST_C,
		PH_SP_A,
		PH_SP_B,
		PH_SP_C,
		PH_WR_PRE,
		PH_WR_SET,
		PH_WR_HI,
		PH_WR_LO,
		PH_AK_LO,
		PH_AK_HI,
		PH_AK_POLL,
		PH_AK_END,
		PH_RD_LO,
		PH_RD_HI,
		PH_RD_END,
		PH_AS_PRE,
		PH_AS_SET,
		PH_AS_HI,
		PH_AS_LO
	} phase_t;

	// one tick as it sits in the queue
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
	} item_t;

	// configuration seen by the sequencer
	typedef struct packed {
		logic [7:0] half_period_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	// one result tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_ok;
	} res_t;

endpackage

[design/i2cm_chan_if.sv]
// valid/ready channel interfaces of the i2c master bit engine
// tick channel (input) and result channel (output); no dependencies

interface i2cm_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] op;
	logic [7:0] tx_byte;
	logic       ack_to_send;
	logic       sda_in;

	modport source (output valid, cmd_valid, op, tx_byte, ack_to_send, sda_in, input ready);
	modport sink   (input valid, cmd_valid, op, tx_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_ok;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_ok, input ready);
	modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_ok, output ready);
endinterface

[design/i2c_master_bit_engine_core.sv]
// top level of the i2c master bit engine: config registers, front end, back end
// depends on i2cm_pkg, i2cm_chan_if, i2cm_front and i2cm_back

// An I2C master line sequencer driven by time ticks. Every transfer on the tick
// channel is one tick: it may carry a command (start, stop, write byte, read byte
// then ACK/NACK) and always carries the sampled SDA level. Every tick gives exactly
// one transfer on the result channel with the SCL level, the SDA drive and level,
// busy and done flags, the receive shift register and the last write-ACK status.
// A command is taken only on a tick that finds the sequencer idle; otherwise it is
// dropped. Each line phase is held for half_period_ticks ticks (0 acts as 1); after
// a write byte SDA is polled with SCL high for up to ack_timeout ticks (0 acts as
// 1), and if no ACK comes the block issues a stop itself and reports ack_ok 0.
// Rate: one tick per clock cycle while the result channel is ready. The front end
// classifies and queues ticks (QUEUE_DEPTH entries); the back end registers the
// whole phase step of one tick in a result register, which holds a stalled result.
// Configuration is written through wr_en/wr_idx/wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.

module i2c_master_bit_engine_core
	import i2cm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	i2cm_tick_if.sink            tick,
	i2cm_res_if.source           res,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_idx,
	input  logic [7:0]           wr_data
);

	cfg_t  cfg_q;
	logic  q_valid, q_ready;
	item_t q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
			cfg_q.ack_timeout       <= ACK_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= wr_data;
				REG_ACK_TIMEOUT: cfg_q.ack_timeout       <= wr_data;
			endcase
		end
	end

	// front end: classify and queue ticks
	i2cm_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// back end: phase sequencer and result register
	i2cm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.res     (res)
	);

	// a tick taken from the queue always lands in the result register
	a_pop_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> res.valid)
		else $error("queued tick did not produce a result");

	// a finished command leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> !res.busy_res)
		else $error("done reported while still busy");

	// released sda reads as high
	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.sda_drive |-> res.sda_level)
		else $error("sda released but level low");

	// an idle result releases sda only after an acknowledged write
	a_poll_released: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.busy_res && !res.sda_drive |-> res.ack_ok)
		else $error("sda released while idle without an acknowledged write");

endmodule

[design/i2cm_front.sv]
// front end: takes tick transfers, classifies the command, queues the tick
// depends on i2cm_pkg and i2cm_tick_if

module i2cm_front
	import i2cm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	i2cm_tick_if.sink    tick,
	output logic         q_valid,
	input  logic         q_ready,
	output item_t        q_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            mem_q [DEPTH];
	item_t            item;
	logic             push, pop;

	// classify
	always_comb begin
		item.tx_byte     = tick.tx_byte;
		item.ack_to_send = tick.ack_to_send;
		item.sda_in      = tick.sda_in;
		if (!tick.cmd_valid) begin
			item.cmd = CMD_NONE;
		end else begin
			unique case (tick.op)
				OP_START: item.cmd = CMD_START;
				OP_STOP:  item.cmd = CMD_STOP;
				OP_WRITE: item.cmd = CMD_WRITE;
				OP_READ:  item.cmd = CMD_READ;
			endcase
		end
	end

	assign tick.ready = (count_q != CNT_W'(DEPTH));
	assign push       = tick.valid && tick.ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_valid && q_ready;
	assign q_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

[design/i2cm_back.sv]
// back end: line phase sequencer, one queued tick per cycle while the result channel is ready, result register
// depends on i2cm_pkg and i2cm_res_if

module i2cm_back
	import i2cm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         q_valid,
	output logic         q_ready,
	input  item_t        q_item,
	i2cm_res_if.source   res
);

	phase_t     phase_q, phase_d, ph;
	logic       cur_wr_q, cur_wr_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] rx_q, rx_d;
	logic [7:0] delay_q, delay_d;
	logic [7:0] poll_q, poll_d;
	logic       ack_bit_q, ack_bit_d;
	logic       ack_res_q, ack_res_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       drive, done;
	logic [7:0] hp, to;
	logic       out_valid_q, load;
	res_t       res_q, res_d;

	assign hp = (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks;
	assign to = (cfg.ack_timeout == '0) ? 8'd1 : cfg.ack_timeout;

	always_comb begin
		phase_d   = phase_q;
		cur_wr_d  = cur_wr_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		rx_d      = rx_q;
		delay_d   = delay_q;
		poll_d    = poll_q;
		ack_bit_d = ack_bit_q;
		ack_res_d = ack_res_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		drive     = 1'b1;
		done      = 1'b0;

		// new command, only when idle
		if (phase_q == PH_IDLE && q_item.cmd != CMD_NONE) begin
			cur_wr_d = (q_item.cmd == CMD_WRITE);
			delay_d  = '0;
			unique case (q_item.cmd)
				CMD_START: phase_d = PH_ST_A;
				CMD_STOP:  phase_d = PH_SP_A;
				CMD_WRITE: begin
					shift_d = q_item.tx_byte;
					phase_d = PH_WR_PRE;
				end
				CMD_READ: begin
					ack_bit_d = q_item.ack_to_send;
					rx_d      = '0;
					bit_cnt_d = '0;
					phase_d   = PH_RD_LO;
				end
				default: phase_d = phase_q;
			endcase
		end
		ph = phase_d;

		// line levels
		unique case (ph)
			PH_ST_A:    begin scl_d = 1'b1; sda_d = 1'b1; end
			PH_ST_B:    begin scl_d = 1'b1; sda_d = 1'b0; end
			PH_ST_C:    begin scl_d = 1'b0; sda_d = 1'b0; end
			PH_SP_A:    sda_d = 1'b0;
			PH_SP_B:    begin scl_d = 1'b1; sda_d = 1'b0; end
			PH_SP_C:    begin scl_d = 1'b1; sda_d = 1'b1; end
			PH_WR_PRE:  scl_d = 1'b0;
			PH_WR_SET:  begin scl_d = 1'b0; sda_d = shift_d[7]; end
			PH_WR_HI:   scl_d = 1'b1;
			PH_WR_LO:   scl_d = 1'b0;
			PH_AK_LO:   begin scl_d = 1'b0; drive = 1'b0; end
			PH_AK_HI:   begin scl_d = 1'b1; drive = 1'b0; end
			PH_AK_POLL: begin scl_d = 1'b1; drive = 1'b0; end
			PH_AK_END:  begin scl_d = 1'b0; drive = 1'b0; end
			PH_RD_LO:   begin scl_d = 1'b0; drive = 1'b0; end
			PH_RD_HI:   begin scl_d = 1'b1; drive = 1'b0; end
			PH_RD_END:  begin scl_d = 1'b0; drive = 1'b0; end
			PH_AS_PRE:  scl_d = 1'b0;
			PH_AS_SET:  begin scl_d = 1'b0; sda_d = ack_bit_d; end
			PH_AS_HI:   scl_d = 1'b1;
			PH_AS_LO:   scl_d = 1'b0;
			default:    drive = !(cur_wr_d && ack_res_q);
		endcase

		// phase timing
		if (ph == PH_AK_POLL) begin
			poll_d = poll_q + 8'd1;
			if (!q_item.sda_in) begin
				phase_d = PH_AK_END;
				delay_d = '0;
			end else if (poll_d >= to) begin
				phase_d = PH_SP_A;
				delay_d = '0;
			end
		end else if (ph != PH_IDLE) begin
			delay_d = delay_d + 8'd1;
			if (delay_d >= hp) begin
				delay_d = '0;
				unique case (ph)
					PH_ST_A:   phase_d = PH_ST_B;
					PH_ST_B:   phase_d = PH_ST_C;
					PH_SP_A:   phase_d = PH_SP_B;
					PH_SP_B:   phase_d = PH_SP_C;
					PH_SP_C: begin
						if (cur_wr_d) ack_res_d = 1'b0;
						done = 1'b1;
					end
					PH_WR_PRE: begin
						bit_cnt_d = '0;
						phase_d   = PH_WR_SET;
					end
					PH_WR_SET: phase_d = PH_WR_HI;
					PH_WR_HI:  phase_d = PH_WR_LO;
					PH_WR_LO: begin
						shift_d   = {shift_d[6:0], 1'b0};
						bit_cnt_d = bit_cnt_d + 4'd1;
						phase_d   = (bit_cnt_d >= 4'd8) ? PH_AK_LO : PH_WR_SET;
					end
					PH_AK_LO:  phase_d = PH_AK_HI;
					PH_AK_HI: begin
						poll_d  = '0;
						phase_d = PH_AK_POLL;
					end
					PH_AK_END: begin
						ack_res_d = 1'b1;
						done      = 1'b1;
					end
					PH_RD_LO:  phase_d = PH_RD_HI;
					PH_RD_HI: begin
						rx_d      = {rx_d[6:0], q_item.sda_in};
						bit_cnt_d = bit_cnt_d + 4'd1;
						phase_d   = (bit_cnt_d >= 4'd8) ? PH_RD_END : PH_RD_LO;
					end
					PH_RD_END: phase_d = PH_AS_PRE;
					PH_AS_PRE: phase_d = PH_AS_SET;
					PH_AS_SET: phase_d = PH_AS_HI;
					PH_AS_HI:  phase_d = PH_AS_LO;
					default:   done = 1'b1;
				endcase
				if (done) phase_d = PH_IDLE;
			end
		end

		res_d.scl_level = scl_d;
		res_d.sda_level = drive ? sda_d : 1'b1;
		res_d.sda_drive = drive;
		res_d.busy_res  = (phase_d != PH_IDLE);
		res_d.done_res  = done;
		res_d.rx_byte   = rx_d;
		res_d.ack_ok    = ack_res_d;
	end

	assign q_ready = !out_valid_q || res.ready;
	assign load    = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cur_wr_q    <= 1'b0;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			rx_q        <= '0;
			delay_q     <= '0;
			poll_q      <= '0;
			ack_bit_q   <= 1'b0;
			ack_res_q   <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q   <= phase_d;
				cur_wr_q  <= cur_wr_d;
				bit_cnt_q <= bit_cnt_d;
				shift_q   <= shift_d;
				rx_q      <= rx_d;
				delay_q   <= delay_d;
				poll_q    <= poll_d;
				ack_bit_q <= ack_bit_d;
				ack_res_q <= ack_res_d;
				scl_q     <= scl_d;
				sda_q     <= sda_d;
			end
			if (q_ready) out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_d;
	end

	assign res.valid     = out_valid_q;
	assign res.scl_level = res_q.scl_level;
	assign res.sda_level = res_q.sda_level;
	assign res.sda_drive = res_q.sda_drive;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.rx_byte   = res_q.rx_byte;
	assign res.ack_ok    = res_q.ack_ok;

endmodule

[bench/tb.sv]
// self-checking bench for i2c_master_bit_engine_core: tick stimulus, line-level prediction
// depends on i2cm_pkg, i2cm_chan_if and the core itself
`timescale 1ns / 100ps

module tb
	import i2cm_pkg::*;
();

	// tracks the sequencer line by line and holds the line results still owed by the core
	class i2c_line_scoreboard;
		phase_t     ph;
		logic [1:0] cur_op;
		logic [3:0] bit_cnt;
		logic [7:0] tx_shift;
		logic [7:0] rx_shift;
		logic [7:0] dly;
		logic [7:0] polls;
		logic       ack_send;
		logic       ack_res;
		logic       scl;
		logic       sda;
		logic [7:0] half_period;
		logic [7:0] ack_limit;
		res_t       line_results_q[$];
		int         mismatches;

		function new();
			half_period = HALF_PERIOD_RST;
			ack_limit   = ACK_TIMEOUT_RST;
			ph          = PH_IDLE;
			cur_op      = 2'd0;
			bit_cnt     = 4'd0;
			tx_shift    = 8'd0;
			rx_shift    = 8'd0;
			dly         = 8'd0;
			polls       = 8'd0;
			ack_send    = 1'b0;
			ack_res     = 1'b0;
			scl         = 1'b1;
			sda         = 1'b1;
			mismatches  = 0;
		endfunction

		function void enter(phase_t p);
			ph  = p;
			dly = 8'd0;
		endfunction

		// one accepted tick: advance the sequencer and queue the line result it gives
		function void note_tick(logic cv, logic [1:0] op, logic [7:0] tx, logic ack_in,
			logic sda_in);
			logic [7:0] hp;
			logic [7:0] lim;
			logic       drive;
			logic       done;
			res_t       r;
			hp    = (half_period == 8'd0) ? 8'd1 : half_period;
			lim   = (ack_limit == 8'd0) ? 8'd1 : ack_limit;
			done  = 1'b0;
			drive = 1'b1;
			if (ph == PH_IDLE && cv) begin
				cur_op = op;
				case (op)
					OP_START: enter(PH_ST_A);
					OP_STOP:  enter(PH_SP_A);
					OP_WRITE: begin
						tx_shift = tx;
						enter(PH_WR_PRE);
					end
					default: begin
						ack_send = ack_in;
						rx_shift = 8'd0;
						bit_cnt  = 4'd0;
						enter(PH_RD_LO);
					end
				endcase
			end
			case (ph)
				PH_ST_A: begin scl = 1'b1; sda = 1'b1; end
				PH_ST_B: begin scl = 1'b1; sda = 1'b0; end
				PH_ST_C: begin scl = 1'b0; sda = 1'b0; end
				PH_SP_A: sda = 1'b0;
				PH_SP_B: begin scl = 1'b1; sda = 1'b0; end
				PH_SP_C: begin scl = 1'b1; sda = 1'b1; end
				PH_WR_PRE, PH_WR_LO, PH_AS_PRE, PH_AS_LO: scl = 1'b0;
				PH_WR_SET: begin scl = 1'b0; sda = tx_shift[7]; end
				PH_WR_HI, PH_AS_HI: scl = 1'b1;
				PH_AK_LO, PH_AK_END, PH_RD_LO, PH_RD_END: begin scl = 1'b0; drive = 1'b0; end
				PH_AK_HI, PH_AK_POLL, PH_RD_HI: begin scl = 1'b1; drive = 1'b0; end
				PH_AS_SET: begin scl = 1'b0; sda = ack_send; end
				default: drive = !(cur_op == OP_WRITE && ack_res);
			endcase
			if (ph == PH_AK_POLL) begin
				polls = polls + 8'd1;
				if (!sda_in)
					enter(PH_AK_END);
				else if (polls >= lim)
					enter(PH_SP_A);
			end else if (ph != PH_IDLE) begin
				dly = dly + 8'd1;
				if (dly >= hp) begin
					case (ph)
						PH_ST_A: enter(PH_ST_B);
						PH_ST_B: enter(PH_ST_C);
						PH_SP_A: enter(PH_SP_B);
						PH_SP_B: enter(PH_SP_C);
						PH_SP_C: begin
							if (cur_op == OP_WRITE)
								ack_res = 1'b0;
							done = 1'b1;
						end
						PH_WR_PRE: begin
							bit_cnt = 4'd0;
							enter(PH_WR_SET);
						end
						PH_WR_SET: enter(PH_WR_HI);
						PH_WR_HI: enter(PH_WR_LO);
						PH_WR_LO: begin
							tx_shift = tx_shift << 1;
							bit_cnt  = bit_cnt + 4'd1;
							enter(bit_cnt >= 4'd8 ? PH_AK_LO : PH_WR_SET);
						end
						PH_AK_LO: enter(PH_AK_HI);
						PH_AK_HI: begin
							polls = 8'd0;
							enter(PH_AK_POLL);
						end
						PH_AK_END: begin
							ack_res = 1'b1;
							done    = 1'b1;
						end
						PH_RD_LO: enter(PH_RD_HI);
						PH_RD_HI: begin
							rx_shift = {rx_shift[6:0], sda_in};
							bit_cnt  = bit_cnt + 4'd1;
							enter(bit_cnt >= 4'd8 ? PH_RD_END : PH_RD_LO);
						end
						PH_RD_END: enter(PH_AS_PRE);
						PH_AS_PRE: enter(PH_AS_SET);
						PH_AS_SET: enter(PH_AS_HI);
						PH_AS_HI: enter(PH_AS_LO);
						default: done = 1'b1;
					endcase
					if (done)
						enter(PH_IDLE);
				end
			end
			r.scl_level = scl;
			r.sda_level = drive ? sda : 1'b1;
			r.sda_drive = drive;
			r.busy_res  = (ph != PH_IDLE);
			r.done_res  = done;
			r.rx_byte   = rx_shift;
			r.ack_ok    = ack_res;
			line_results_q.push_back(r);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_line(res_t got);
			res_t want;
			if (line_results_q.size() == 0) begin
				$error("line result with nothing outstanding");
				mismatches++;
				return;
			end
			want = line_results_q.pop_front();
			check_field("scl_level", want.scl_level, got.scl_level);
			check_field("sda_level", want.sda_level, got.sda_level);
			check_field("sda_drive", want.sda_drive, got.sda_drive);
			check_field("busy_res", want.busy_res, got.busy_res);
			check_field("done_res", want.done_res, got.done_res);
			check_field("rx_byte", want.rx_byte, got.rx_byte);
			check_field("ack_ok", want.ack_ok, got.ack_ok);
		endfunction
	endclass

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en  = 1'b0;
	logic [REG_IDX_W-1:0] wr_idx;
	logic [7:0]           wr_data;

	i2cm_tick_if tick();
	i2cm_res_if  res();

	i2c_master_bit_engine_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.res     (res),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	i2c_line_scoreboard sb;

	// knobs set by the main sequence for the tick driver and the result taker
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_req     = 0;
	int ticks_sent   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// poll number at which the slave pulls sda low, 0 for never
	function automatic int pick_ack();
		int lim;
		int r;
		lim = (sb.ack_limit == 8'd0) ? 1 : sb.ack_limit;
		r   = $urandom_range(99);
		if (r < 40)
			return 1;
		if (r < 55)
			return lim;
		if (r < 75)
			return $urandom_range(1, lim);
		return 0;
	endfunction

	// one tick transfer; called right after a rising edge, returns at the accepting edge
	task automatic send_tick(logic cv, logic [1:0] op, logic [7:0] tx, logic ak, logic sd);
		int g;
		if ($urandom_range(99) < send_gap_pct) begin
			g = gap_len();
			tick.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		tick.valid       <= 1'b1;
		tick.cmd_valid   <= cv;
		tick.op          <= op;
		tick.tx_byte     <= tx;
		tick.ack_to_send <= ak;
		tick.sda_in      <= sd;
		do @(posedge clk); while (!tick.ready);
		sb.note_tick(cv, op, tx, ak, sd);
		ticks_sent++;
	endtask

	// issue a command on an idle sequencer and tick it through to the end;
	// for a read, data is also the byte the slave puts on sda
	task automatic do_cmd(logic [1:0] op, logic [7:0] data, logic ak, int ack_at);
		logic sd;
		logic cv;
		send_tick(1'b1, op, data, ak, 1'($urandom_range(1)));
		while (sb.ph != PH_IDLE) begin
			sd = 1'($urandom_range(1));
			if (sb.ph == PH_AK_POLL)
				sd = !(ack_at != 0 && int'(sb.polls) + 1 == ack_at);
			else if (sb.ph == PH_RD_HI)
				sd = data[7 - sb.bit_cnt];
			// commands while busy must be dropped
			cv = ($urandom_range(99) < 15);
			send_tick(cv, 2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)), sd);
		end
	endtask

	// mostly a framed transfer (start, writes, reads, stop), sometimes a lone command
	task automatic random_txn();
		if ($urandom_range(99) < 80) begin
			do_cmd(OP_START, 8'($urandom), 1'($urandom_range(1)), 0);
			repeat ($urandom_range(1, 2))
				do_cmd(OP_WRITE, 8'($urandom), 1'($urandom_range(1)), pick_ack());
			repeat ($urandom_range(0, 1))
				do_cmd(OP_READ, 8'($urandom), 1'($urandom_range(1)), 0);
			do_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(1)), 0);
		end else begin
			do_cmd(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)), pick_ack());
		end
		// idle ticks, payload still random
		repeat ($urandom_range(0, 3))
			send_tick(1'b0, 2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)),
				1'($urandom_range(1)));
	endtask

	// stop offering ticks until every line result is back
	task automatic drain();
		tick.valid <= 1'b0;
		while (sb.line_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers, only while the core is idle
	task automatic write_cfg(logic [7:0] hp, logic [7:0] lim);
		wr_en   <= 1'b1;
		wr_idx  <= REG_HALF_PERIOD;
		wr_data <= hp;
		@(posedge clk);
		wr_idx  <= REG_ACK_TIMEOUT;
		wr_data <= lim;
		@(posedge clk);
		wr_en   <= 1'b0;
		sb.half_period = hp;
		sb.ack_limit   = lim;
	endtask

	// result taker: checks every transfer, stalls at random and on request
	initial begin
		int   stall_left;
		res_t got;
		stall_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				got.scl_level = res.scl_level;
				got.sda_level = res.sda_level;
				got.sda_drive = res.sda_drive;
				got.busy_res  = res.busy_res;
				got.done_res  = res.done_res;
				got.rx_byte   = res.rx_byte;
				got.ack_ok    = res.ack_ok;
				sb.check_line(got);
			end
			if (hold_req > 0) begin
				// long hold-off so the core backs up and stalls its tick input
				hold_req--;
				res.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if ($urandom_range(99) < recv_gap_pct) begin
				stall_left = gap_len() - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// main sequence
	initial begin
		logic [7:0] hp_set[3];
		logic [7:0] lim_set[3];
		int         start_cnt;
		hp_set  = '{8'd2, 8'd1, 8'd0};
		lim_set = '{8'd3, 8'd1, 8'd2};
		sb = new();
		tick.valid       <= 1'b0;
		tick.cmd_valid   <= 1'b0;
		tick.op          <= OP_START;
		tick.tx_byte     <= 8'd0;
		tick.ack_to_send <= 1'b0;
		tick.sda_in      <= 1'b1;
		wr_idx           <= REG_HALF_PERIOD;
		wr_data          <= 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: start, then stop with scl still low from the start
		do_cmd(OP_START, 8'h00, 1'b0, 0);
		do_cmd(OP_STOP, 8'h00, 1'b0, 0);
		drain();

		// directed: fastest phases, short ack window
		write_cfg(8'd1, 8'd3);
		do_cmd(OP_START, 8'h00, 1'b0, 0);
		do_cmd(OP_WRITE, 8'hFF, 1'b0, 1);
		do_cmd(OP_WRITE, 8'h00, 1'b1, 3);   // ack on the very last poll
		// idle ticks after an acked write leave sda released
		repeat (3) send_tick(1'b0, OP_STOP, 8'h00, 1'b0, 1'b1);
		do_cmd(OP_READ, 8'hFF, 1'b0, 0);
		do_cmd(OP_READ, 8'h96, 1'b1, 0);
		do_cmd(OP_WRITE, 8'hA5, 1'b0, 0);   // no ack, core stops on its own
		repeat (2) send_tick(1'b0, OP_READ, 8'hFF, 1'b1, 1'b0);
		do_cmd(OP_STOP, 8'hFF, 1'b1, 0);
		drain();

		// zero registers act as one
		write_cfg(8'd0, 8'd0);
		do_cmd(OP_START, 8'h00, 1'b0, 0);
		do_cmd(OP_WRITE, 8'h5A, 1'b0, 0);
		do_cmd(OP_START, 8'h00, 1'b0, 0);
		do_cmd(OP_WRITE, 8'h3C, 1'b0, 1);
		do_cmd(OP_READ, 8'h81, 1'b0, 0);
		do_cmd(OP_STOP, 8'h00, 1'b0, 0);
		drain();

		// random phases, the middle one with no random gaps on either side but a long result hold
		for (int i = 0; i < 3; i++) begin
			write_cfg(hp_set[i], lim_set[i]);
			send_gap_pct = (i % 2 == 0) ? 20 : 0;
			recv_gap_pct = (i % 2 == 0) ? 20 : 0;
			if (i == 1)
				hold_req = 80;
			start_cnt = ticks_sent;
			while (ticks_sent - start_cnt < 20)
				random_txn();
			drain();
		end

		// slow half period, a single start is enough
		send_gap_pct = 10;
		recv_gap_pct = 10;
		write_cfg(8'd8, 8'd1);
		do_cmd(OP_START, 8'h00, 1'b0, 0);
		drain();

		if (sb.mismatches == 0)
			$display("[i2c_master_bit_engine_core] OK");
		else
			$display("[i2c_master_bit_engine_core] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[i2c_master_bit_engine_core] ERROR");
		$finish;
	end

endmodule
